// File: src/morton_grid_occupancy_lookup_core_macros.svh
// Assertion macros used by the checker file.
`ifndef MORTON_GRID_OCCUPANCY_LOOKUP_CORE_MACROS_SVH
`define MORTON_GRID_OCCUPANCY_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MGOL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mgol assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MGOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mgol assertion failed");

`endif

// File: src/mgol_pkg.sv
// Package: constants, codes and types of the Morton grid lookup core.
package mgol_pkg;

  localparam int TILE_SHIFT  = 4;
  localparam int MAX_SIDE    = 64;
  localparam int ENTITY_BITS = 10;

  localparam int CELLS     = MAX_SIDE * MAX_SIDE;
  localparam int CELL_BITS = $clog2(CELLS);
  localparam int SIDE_W    = 9;
  localparam int SQ_W      = 2 * SIDE_W;
  localparam int POS_W     = 16;
  localparam int CODE_W    = 16;
  localparam int ENT_W     = 10;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int GS_W   = 7;
  localparam logic [GS_W-1:0] GRID_SIDE_RST = 7'd64;
  localparam logic [ADDR_W-3:0] REG_GRID_SIDE = 1'b0;

  typedef enum logic [1:0] {
    KIND_CLEAR        = 2'd0,
    KIND_INSERT_ENEMY = 2'd1,
    KIND_INSERT_ITEM  = 2'd2,
    KIND_QUERY        = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  typedef struct packed {
    logic                   vld;
    logic [ENTITY_BITS-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic in_grid;
    logic is_query;
  } meta_t;

  typedef struct packed {
    logic             in_grid;
    logic             enemy_hit;
    logic [ENT_W-1:0] enemy_found;
    logic             item_hit;
    logic [ENT_W-1:0] item_found;
  } result_t;

endpackage

// File: src/mgol_item_if.sv
// Channel interfaces: input items and result beats.
interface mgol_item_if;
  import mgol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ENT_W-1:0]        entity_index;

  modport source (output valid, kind, pos_x, pos_y, entity_index, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, entity_index, output ready);
endinterface

interface mgol_result_if;
  import mgol_pkg::*;
  logic             valid;
  logic             ready;
  logic             in_grid;
  logic             enemy_hit;
  logic [ENT_W-1:0] enemy_found;
  logic             item_hit;
  logic [ENT_W-1:0] item_found;

  modport source (output valid, in_grid, enemy_hit, enemy_found, item_hit, item_found,
                  input ready);
  modport sink   (input valid, in_grid, enemy_hit, enemy_found, item_hit, item_found,
                  output ready);
endinterface

// File: src/morton_grid_occupancy_lookup_core.sv
// Top level: two-layer Morton-ordered occupancy grid with insert, query and clear.
// Each beat on in_i carries a kind, a pixel position and an entity index; every
// beat yields exactly one result beat on out_o, in order. Inserts and queries
// are taken one per cycle while no sweep runs and back pressure allows, and
// each result passes the memory read stage, then the output register; back
// pressure on out_o stalls in_i only once both stages are full. After a clear
// beat is accepted, the single write port of each layer memory sweeps all
// 4096 cells, one per cycle, so in_i stays not ready until the sweep ends.
// The same sweep runs right after reset before the first beat is taken; APB
// writes are accepted throughout. grid_side lives at APB address 0 and
// its effective side saturates at 64; a position maps to a cell only when both
// coordinates are non-negative, each tile (position >> 4) is below 256, and
// the interleaved tile index is below grid_side squared.
module morton_grid_occupancy_lookup_core
  import mgol_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  mgol_item_if.sink         in_i,
  mgol_result_if.source     out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // config register
  logic [GS_W-1:0] grid_side_q, grid_side_d;
  logic            cfg_wr;

  // control
  state_e               state_q, state_d;
  logic [CELL_BITS-1:0] sweep_q, sweep_d;
  logic                 s1_vld_q, s1_vld_d;
  logic                 out_vld_q, out_vld_d;
  logic                 s1_adv, accept;

  // payload
  meta_t   s1_meta_q, s1_meta_d;
  result_t out_q, out_d;
  entry_t  en_rd_q, it_rd_q;

  // address path
  logic [POS_W-1:0]     tx_full, ty_full;
  logic                 tile_miss;
  logic [CODE_W-1:0]    code;
  logic [SIDE_W-1:0]    side;
  logic [SQ_W-1:0]      side_sq;
  logic                 in_grid_c;
  logic [CELL_BITS-1:0] cell_addr;

  // memory ports
  entry_t               en_mem [CELLS];
  entry_t               it_mem [CELLS];
  logic                 en_we, it_we, rd_en;
  logic [CELL_BITS-1:0] waddr;
  entry_t               wdata;

  // ---------------- APB ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_GRID_SIDE);
  assign grid_side_d = cfg_wr ? pwdata[GS_W-1:0] : grid_side_q;
  assign prdata = (paddr[ADDR_W-1:2] == REG_GRID_SIDE) ?
                  {{(DATA_W-GS_W){1'b0}}, grid_side_q} : '0;

  // ---------------- locate ----------------
  // Tile is a logical shift; negative positions and tiles past 8 bits miss.
  assign tx_full   = POS_W'(unsigned'(in_i.pos_x)) >> TILE_SHIFT;
  assign ty_full   = POS_W'(unsigned'(in_i.pos_y)) >> TILE_SHIFT;
  assign tile_miss = in_i.pos_x[POS_W-1] || in_i.pos_y[POS_W-1] ||
                     (|tx_full[POS_W-1:8]) || (|ty_full[POS_W-1:8]);

  // x on even bits, y on odd bits
  always_comb begin
    code = '0;
    for (int i = 0; i < 8; i++) begin
      code[2*i]   = tx_full[i];
      code[2*i+1] = ty_full[i];
    end
  end

  assign side      = ({2'b00, grid_side_q} > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                               : {2'b00, grid_side_q};
  assign side_sq   = side * side;
  assign in_grid_c = !tile_miss && ({{(SQ_W-CODE_W){1'b0}}, code} < side_sq);
  assign cell_addr = code[CELL_BITS-1:0];

  // ---------------- handshake ----------------
  assign s1_adv     = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_RUN) && (!s1_vld_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      ST_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == CELL_BITS'(CELLS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && in_i.kind == KIND_CLEAR) begin
          state_d = ST_SWEEP;
          sweep_d = '0;
        end
      end
      default: begin
        state_d = ST_SWEEP;
        sweep_d = '0;
      end
    endcase
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_vld_q && s1_adv) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // ---------------- memory ports ----------------
  // Sweep and item writes never share a cycle; a query reads cells written
  // by earlier beats at earlier edges, so no forwarding is needed.
  assign en_we = (state_q == ST_SWEEP) ||
                 (accept && in_i.kind == KIND_INSERT_ENEMY && in_grid_c);
  assign it_we = (state_q == ST_SWEEP) ||
                 (accept && in_i.kind == KIND_INSERT_ITEM && in_grid_c);
  assign rd_en = accept && in_i.kind == KIND_QUERY;
  assign waddr = (state_q == ST_SWEEP) ? sweep_q : cell_addr;
  assign wdata = (state_q == ST_SWEEP) ? entry_t'('0)
                                       : entry_t'{vld: 1'b1,
                                                  idx: in_i.entity_index[ENTITY_BITS-1:0]};

  always_ff @(posedge clk_i) begin
    if (en_we) begin
      en_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      en_rd_q <= en_mem[cell_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (it_we) begin
      it_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      it_rd_q <= it_mem[cell_addr];
    end
  end

  // ---------------- result ----------------
  assign s1_meta_d = '{in_grid: (in_i.kind != KIND_CLEAR) && in_grid_c,
                       is_query: in_i.kind == KIND_QUERY};

  always_comb begin
    out_d = '0;
    out_d.in_grid = s1_meta_q.in_grid;
    if (s1_meta_q.in_grid && s1_meta_q.is_query) begin
      out_d.enemy_hit   = en_rd_q.vld;
      out_d.enemy_found = en_rd_q.vld ? ENT_W'(en_rd_q.idx) : '0;
      out_d.item_hit    = it_rd_q.vld;
      out_d.item_found  = it_rd_q.vld ? ENT_W'(it_rd_q.idx) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= s1_meta_d;
    end
    if (s1_vld_q && s1_adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RST;
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      s1_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      grid_side_q <= grid_side_d;
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      s1_vld_q    <= s1_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.in_grid     = out_q.in_grid;
  assign out_o.enemy_hit   = out_q.enemy_hit;
  assign out_o.enemy_found = out_q.enemy_found;
  assign out_o.item_hit    = out_q.item_hit;
  assign out_o.item_found  = out_q.item_found;

endmodule

// File: src/mgol_checker.sv
// Port-level checker for the Morton grid lookup core, bound to the top level.
`include "morton_grid_occupancy_lookup_core_macros.svh"

module mgol_checker
  import mgol_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [1:0]       in_kind_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_in_grid_i,
  input logic             out_enemy_hit_i,
  input logic [ENT_W-1:0] out_enemy_found_i,
  input logic             out_item_hit_i,
  input logic [ENT_W-1:0] out_item_found_i
);

  logic clear_beat;
  logic out_stall;
  logic out_miss;
  logic out_empty;
  logic found_ok;

  assign clear_beat = in_valid_i && in_ready_i && (in_kind_i == KIND_CLEAR);
  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_miss   = out_valid_i && !out_in_grid_i;
  assign out_empty  = !out_enemy_hit_i && !out_item_hit_i &&
                      (out_enemy_found_i == '0) && (out_item_found_i == '0);
  // an index is reported only with its hit
  assign found_ok   = (out_enemy_hit_i || (out_enemy_found_i == '0)) &&
                      (out_item_hit_i || (out_item_found_i == '0));

  // a pending result beat stays offered
  `MGOL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)

  // a clear beat starts the sweep, which blocks the next beat
  `MGOL_ASSERT_NEXT(a_clear_blocks, clk_i, rst_ni, clear_beat, !in_ready_i)

  // nothing is found outside the grid
  `MGOL_ASSERT_NOW(a_miss_empty, clk_i, rst_ni, out_miss, out_empty)

  `MGOL_ASSERT_NOW(a_found_needs_hit, clk_i, rst_ni, out_valid_i, found_ok)

endmodule

bind morton_grid_occupancy_lookup_core mgol_checker u_mgol_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_kind_i         (in_i.kind),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_in_grid_i     (out_o.in_grid),
  .out_enemy_hit_i   (out_o.enemy_hit),
  .out_enemy_found_i (out_o.enemy_found),
  .out_item_hit_i    (out_o.item_hit),
  .out_item_found_i  (out_o.item_found)
);

// File: dv/morton_grid_occupancy_lookup_core_tb.sv
// Self-checking testbench for the Morton grid occupancy lookup core.
module morton_grid_occupancy_lookup_core_tb;
  import mgol_pkg::*;

  // Run shape: a directed opening, then random phases, each under its own grid_side.
  localparam int N_PHASES  = 8;
  localparam int PHASE_OPS = 130;

  // One grid operation as driven on the item channel.
  typedef struct {
    kind_e                   kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ENT_W-1:0]        entity_index;
  } grid_op_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mgol_item_if   item_bus ();
  mgol_result_if result_bus ();

  morton_grid_occupancy_lookup_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (item_bus),
    .out_o   (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the grid: both layers plus the programmed side.
  bit               enemy_occupied [CELLS];
  bit [ENT_W-1:0]   enemy_entity   [CELLS];
  bit               item_occupied  [CELLS];
  bit [ENT_W-1:0]   item_entity    [CELLS];
  logic [GS_W-1:0]  side_cfg = GRID_SIDE_RST;

  grid_op_t pending_ops [$];       // waiting to be driven
  result_t  predicted_results [$]; // accepted, result beat not yet seen
  int       in_flight;             // popped by the driver, result not yet checked

  // Recently inserted positions, reused so that queries actually land on data.
  logic signed [POS_W-1:0] hot_x [$];
  logic signed [POS_W-1:0] hot_y [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned phase_sides [N_PHASES] = '{64, 1, 127, 0, 37, 100, 16, 64};

  int n_errors;
  int n_beats;
  int n_queries;
  int n_query_hits;
  int n_clears;

  // 20-unit clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [ENT_W-1:0] got,
                             input logic [ENT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, want));
  endtask

  // Position -> cell. Negative coordinates and tiles past 255 miss; the
  // interleaved tile code (x on even bits, y on odd) must sit below side^2,
  // with the side saturated at MAX_SIDE.
  function automatic logic locate_cell(input logic signed [POS_W-1:0] px,
                                       input logic signed [POS_W-1:0] py,
                                       input logic [GS_W-1:0] gs,
                                       output logic [CELL_BITS-1:0] cell_idx);
    logic [POS_W-1:0]  tx;
    logic [POS_W-1:0]  ty;
    logic [CODE_W-1:0] code;
    int unsigned       side;
    cell_idx = '0;
    if (px[POS_W-1] || py[POS_W-1]) return 1'b0;
    tx = $unsigned(px) >> TILE_SHIFT;
    ty = $unsigned(py) >> TILE_SHIFT;
    if (tx > 255 || ty > 255) return 1'b0;
    for (int b = 0; b < 8; b++) begin
      code[2*b]   = tx[b];
      code[2*b+1] = ty[b];
    end
    side = (gs > MAX_SIDE) ? MAX_SIDE : gs;
    if (code >= side * side) return 1'b0;
    cell_idx = code[CELL_BITS-1:0];
    return 1'b1;
  endfunction

  // Apply one operation to the shadow grid and return the result beat it yields.
  function automatic result_t grid_step(input grid_op_t op);
    result_t              r;
    logic [CELL_BITS-1:0] c;
    r = '0;
    if (op.kind == KIND_CLEAR) begin
      foreach (enemy_occupied[i]) begin
        enemy_occupied[i] = 1'b0;
        enemy_entity[i]   = '0;
        item_occupied[i]  = 1'b0;
        item_entity[i]    = '0;
      end
      n_clears++;
      return r;
    end
    if (op.kind == KIND_QUERY) n_queries++;
    if (!locate_cell(op.pos_x, op.pos_y, side_cfg, c)) return r;
    r.in_grid = 1'b1;
    case (op.kind)
      KIND_INSERT_ENEMY: begin
        enemy_occupied[c] = 1'b1;
        enemy_entity[c]   = op.entity_index;
      end
      KIND_INSERT_ITEM: begin
        item_occupied[c] = 1'b1;
        item_entity[c]   = op.entity_index;
      end
      default: begin
        if (enemy_occupied[c]) begin
          r.enemy_hit   = 1'b1;
          r.enemy_found = enemy_entity[c];
        end
        if (item_occupied[c]) begin
          r.item_hit   = 1'b1;
          r.item_found = item_entity[c];
        end
        if (r.enemy_hit || r.item_hit) n_query_hits++;
      end
    endcase
    return r;
  endfunction

  // One coordinate: mostly inside the live grid, the rest outside, past
  // tile 255, or anything at all (negatives included).
  function automatic logic signed [POS_W-1:0] rand_coord(input int unsigned tiles);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 65)
      return 16'(($urandom_range(tiles - 1) << TILE_SHIFT) | $urandom_range(15));
    else if (sel < 78)
      return 16'($urandom_range(4095));
    else if (sel < 88)
      return 16'($urandom_range(32767, 4096));
    else
      return 16'($urandom);
  endfunction

  function automatic grid_op_t random_op();
    grid_op_t    op;
    int unsigned roll;
    int unsigned tiles;
    int unsigned k;
    tiles = (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
    if (tiles == 0) tiles = MAX_SIDE;
    roll = $urandom_range(999);
    op.entity_index = ENT_W'($urandom);
    op.pos_x = rand_coord(tiles);
    op.pos_y = rand_coord(tiles);
    // clears are rare: each one costs a full sweep of the store
    if (roll < 12)       op.kind = KIND_CLEAR;
    else if (roll < 330) op.kind = KIND_INSERT_ENEMY;
    else if (roll < 580) op.kind = KIND_INSERT_ITEM;
    else                 op.kind = KIND_QUERY;
    if (op.kind != KIND_CLEAR && hot_x.size() != 0 && $urandom_range(99) < 45) begin
      k = $urandom_range(hot_x.size() - 1);
      op.pos_x = hot_x[k];
      op.pos_y = hot_y[k];
    end
    if (op.kind == KIND_INSERT_ENEMY || op.kind == KIND_INSERT_ITEM) begin
      hot_x.push_back(op.pos_x);
      hot_y.push_back(op.pos_y);
      if (hot_x.size() > 48) begin
        void'(hot_x.pop_front());
        void'(hot_y.pop_front());
      end
    end
    return op;
  endfunction

  task automatic push_op(input kind_e k, input int x, input int y, input int e);
    grid_op_t op;
    op.kind         = k;
    op.pos_x        = 16'(x);
    op.pos_y        = 16'(y);
    op.entity_index = ENT_W'(e);
    pending_ops.push_back(op);
  endtask

  // APB write of grid_side: setup, then access; the register takes it at the
  // edge where psel, penable and pwrite are all high.
  task automatic write_grid_side(input logic [GS_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_GRID_SIDE, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    side_cfg = v;
  endtask

  // Hold off until every queued op has been driven and its result checked,
  // then let the two pipeline stages settle.
  task automatic wait_quiet();
    while (pending_ops.size() != 0 || in_flight != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: predicts each accepted beat, then offers the next one unless
  // the sender decides to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    grid_op_t acc;
    grid_op_t nxt;
    if (!rst_ni) begin
      item_bus.valid        <= 1'b0;
      item_bus.kind         <= KIND_CLEAR;
      item_bus.pos_x        <= '0;
      item_bus.pos_y        <= '0;
      item_bus.entity_index <= '0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        acc.kind         = kind_e'(item_bus.kind);
        acc.pos_x        = item_bus.pos_x;
        acc.pos_y        = item_bus.pos_y;
        acc.entity_index = item_bus.entity_index;
        predicted_results.push_back(grid_step(acc));
        n_beats++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          in_flight++;
          item_bus.valid        <= 1'b1;
          item_bus.kind         <= nxt.kind;
          item_bus.pos_x        <= nxt.pos_x;
          item_bus.pos_y        <= nxt.pos_y;
          item_bus.entity_index <= nxt.entity_index;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat must match the oldest prediction, field by field.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result beat with no item outstanding");
        end else begin
          want = predicted_results.pop_front();
          in_flight--;
          check_field("in_grid", result_bus.in_grid, want.in_grid);
          check_field("enemy_hit", result_bus.enemy_hit, want.enemy_hit);
          check_field("enemy_found", result_bus.enemy_found, want.enemy_found);
          check_field("item_hit", result_bus.item_hit, want.item_hit);
          check_field("item_found", result_bus.item_found, want.item_found);
        end
      end
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 29;
    recv_idle_pct = 84;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset side of 64. The block is still sweeping
    // its store after reset; the driver just waits on ready.
    push_op(KIND_QUERY, 0, 0, 0);                   // empty store
    push_op(KIND_INSERT_ENEMY, 0, 0, 0);
    push_op(KIND_INSERT_ITEM, 0, 0, 1023);
    push_op(KIND_QUERY, 0, 0, 1023);                // both layers hit, index ignored
    push_op(KIND_INSERT_ENEMY, 1023, 1023, 1023);   // last valid cell
    push_op(KIND_INSERT_ITEM, 1008, 1023, 682);
    push_op(KIND_QUERY, 1023, 1023, 0);
    push_op(KIND_INSERT_ENEMY, 0, 0, 341);          // overwrite: last writer wins
    push_op(KIND_QUERY, 0, 0, 0);
    push_op(KIND_INSERT_ENEMY, -1, 0, 5);           // negative x
    push_op(KIND_QUERY, 0, -32768, 0);              // most negative y
    push_op(KIND_INSERT_ITEM, 4096, 16, 7);         // tile just past 255
    push_op(KIND_QUERY, 32767, 32767, 0);
    push_op(KIND_INSERT_ENEMY, 1024, 0, 9);         // tile 64: index past the grid
    push_op(KIND_QUERY, 4095, 4095, 0);             // tiles 255,255
    push_op(KIND_QUERY, 16, 32, 0);                 // valid but never written
    push_op(KIND_CLEAR, -1, -1, 1023);              // fields ignored
    push_op(KIND_QUERY, 0, 0, 0);
    push_op(KIND_QUERY, 1023, 1023, 0);
    push_op(KIND_INSERT_ITEM, 15, 15, 512);
    push_op(KIND_QUERY, 15, 15, 0);
    wait_quiet();

    // Random phases; each drains fully before grid_side moves, which also
    // gives the sender a pause until every result has come back.
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 84;
      end else if (p < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_grid_side(GS_W'(phase_sides[p]));
      repeat (PHASE_OPS) pending_ops.push_back(random_op());
      wait_quiet();
    end

    repeat (10) @(posedge clk_i);
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                predicted_results.size()));
    $display("Covered %0d beats: %0d queries (%0d with a hit), %0d clears,",
             n_beats, n_queries, n_query_hits, n_clears);
    $display("over %0d grid_side phases including sides 0, 1, 64 and 127.", N_PHASES + 1);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (each clear sweeps the whole store).
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
